[sv/iddt_pkg.sv]
// Package for the indent/dedent tracker: token kinds, sequencer states and
// fixed field widths. No dependencies.
`default_nettype none

package iddt_pkg;

    localparam int LEVEL_W = 8;
    localparam int SPACE_W = 8;
    localparam int TAB_W   = 6;

    typedef enum logic [1:0] {
        TOK_INDENT = 2'd0,
        TOK_DEDENT = 2'd1,
        TOK_LINE   = 2'd2,
        TOK_END    = 2'd3
    } token_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_LINE
    } seq_state_t;

    typedef enum logic {
        OP_CONTENT = 1'b0,
        OP_FLUSH   = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

[sv/iddt_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`default_nettype none

module iddt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/indent_dedent_tracker.sv]
// Top level of the offside-rule indent/dedent tracker: level arithmetic,
// the stack sequencer and the output register. Uses iddt_pkg and iddt_ram.
`default_nettype none

// One input transaction describes one source line (leading spaces and tabs)
// or asks for an end-of-source flush. The line's nesting level is the tab
// count plus the space count divided by the indent unit (two or four spaces,
// from cfg_data), rounded half up. Open levels live on a stack held in a
// synchronous RAM; entry 0 is the root at level 0 and is never stored. A
// deeper line pushes and yields Indent, a shallower line yields one Dedent
// per popped level, and a level that falls between two open levels snaps
// to the lower of the two without a token. Every line ends with a line
// marker; a flush pops to the root and ends with End. A push onto a full
// stack is dropped and flagged on that line's marker. The m_tlast bit marks
// the final result of each input transaction. A new transaction is accepted
// only once the sequencer is idle again. After each pop other than the one
// that reaches the root, the new top level must be fetched from the stack
// RAM, which has a registered read. The output register lets the sequencer
// hand over a result while the previous one is being taken; backpressure on
// the m_ side stalls the sequencer. Configuration is taken at any time but
// must only change while the block is idle.
module indent_dedent_tracker #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: bit 0 = unit_is_four
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] space_count, [13:8] tab_count, rest zero
    input  wire logic        s_tuser,   // [0] opcode
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] depth_error, rest zero
    output logic [1:0]       m_tuser,   // [1:0] token_kind
    output logic             m_tlast
);

    import iddt_pkg::*;

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [IDX_W-1:0] TOP_MAX = IDX_W'(STACK_DEPTH - 1);

    // Configuration register
    logic unit_is_four_reg;

    // Sequencer state and per-item context
    seq_state_t           state_reg, state_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 flush_reg;
    logic                 popped_reg;
    logic                 err_reg;

    // Stack top kept in registers; the rest of the stack sits in the RAM
    logic [IDX_W-1:0]     top_idx_reg;
    logic [LEVEL_W-1:0]   top_lvl_reg;

    // Output register
    logic                 m_valid_reg;
    token_kind_t          m_kind_reg;
    logic                 m_err_reg;
    logic                 m_last_reg;

    // Line level from the incoming descriptor
    logic [SPACE_W-1:0]   in_spaces;
    logic [TAB_W-1:0]     in_tabs;
    logic [SPACE_W:0]     space_sum;
    logic [LEVEL_W-1:0]   spc_lvl;
    logic [LEVEL_W-1:0]   in_level;

    // Sequencer decisions
    logic                 out_free;
    logic                 deeper;
    logic                 stack_full;
    logic                 shallower;
    logic [IDX_W-1:0]     pop_idx;

    // Sequencer actions
    logic                 emit;
    token_kind_t          emit_kind;
    logic                 emit_err;
    logic                 emit_last;
    logic                 do_push;
    logic                 do_pop;
    logic                 rd_en;
    logic                 accept;

    logic [LEVEL_W-1:0]   rd_level;

    assign in_spaces = s_tdata[SPACE_W-1:0];
    assign in_tabs   = s_tdata[SPACE_W+TAB_W-1:SPACE_W];

    // Round half up: add half the unit before the shift.
    assign space_sum = {1'b0, in_spaces} + (unit_is_four_reg ? 9'd2 : 9'd1);
    assign spc_lvl   = unit_is_four_reg ? {1'b0, space_sum[SPACE_W:2]}
                                        : space_sum[SPACE_W:1];
    assign in_level = spc_lvl + LEVEL_W'(in_tabs);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Only the first evaluation of an item may push; after a pop a line that
    // sits above the new top simply snaps to it. A flush carries level 0,
    // which can never be deeper.
    assign deeper     = !popped_reg && (level_reg > top_lvl_reg);
    assign stack_full = (top_idx_reg == TOP_MAX);
    assign shallower  = (top_idx_reg != '0) && (level_reg < top_lvl_reg);
    assign pop_idx    = top_idx_reg - 1'b1;

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    if (deeper && !stack_full) begin
                        state_next = ST_LINE;
                    end else if (deeper) begin
                        state_next = ST_IDLE;
                    end else if (shallower) begin
                        state_next = (pop_idx == '0) ? ST_EVAL : ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_LINE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Action logic
    always_comb begin
        emit      = 1'b0;
        emit_kind = TOK_LINE;
        emit_err  = 1'b0;
        emit_last = 1'b0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        rd_en     = 1'b0;
        case (state_reg)
            ST_EVAL: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (deeper && !stack_full) begin
                        emit_kind = TOK_INDENT;
                        do_push   = 1'b1;
                    end else if (deeper) begin
                        // Full stack: the push is dropped and flagged.
                        emit_kind = TOK_LINE;
                        emit_err  = 1'b1;
                        emit_last = 1'b1;
                    end else if (shallower) begin
                        emit_kind = TOK_DEDENT;
                        do_pop    = 1'b1;
                        rd_en     = (pop_idx != '0);
                    end else begin
                        emit_kind = flush_reg ? TOK_END : TOK_LINE;
                        emit_last = 1'b1;
                    end
                end
            end
            ST_LINE: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = TOK_LINE;
                    emit_err  = err_reg;
                    emit_last = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    iddt_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (do_push),
        .waddr (top_idx_reg + 1'b1),
        .wdata (level_reg),
        .re    (rd_en),
        .raddr (pop_idx),
        .rdata (rd_level)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_is_four_reg <= 1'b0;
            state_reg        <= ST_IDLE;
            top_idx_reg      <= '0;
            top_lvl_reg      <= '0;
            popped_reg       <= 1'b0;
            err_reg          <= 1'b0;
            flush_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unit_is_four_reg <= cfg_data;
            end

            if (accept) begin
                flush_reg  <= (opcode_t'(s_tuser) == OP_FLUSH);
                popped_reg <= 1'b0;
                err_reg    <= 1'b0;
            end

            if (do_push) begin
                top_idx_reg <= top_idx_reg + 1'b1;
                top_lvl_reg <= level_reg;
            end else if (do_pop) begin
                top_idx_reg <= pop_idx;
                popped_reg  <= 1'b1;
                // The root level is not stored; every other level is fetched.
                if (pop_idx == '0) begin
                    top_lvl_reg <= '0;
                end
            end else if (state_reg == ST_READ) begin
                top_lvl_reg <= rd_level;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            level_reg <= (opcode_t'(s_tuser) == OP_FLUSH) ? '0 : in_level;
        end
        if (emit) begin
            m_kind_reg <= emit_kind;
            m_err_reg  <= emit_err;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_err_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
